// File: rtl/utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is applied.
`define U8SD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/u8sd_pkg.sv
// Types and constants shared by the UTF-8 stream decoder.
package u8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned ST_W   = 2;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} byte_cls_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK         = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_MALFORMED  = 2'd2
	} status_t;

	typedef struct packed {
		byte_cls_t         cls;
		logic [BYTE_W-1:0] data;
		logic              last;
	} q_entry_t;

endpackage

// File: rtl/u8sd_ifs.sv
// Valid/ready channel interfaces for byte input and character output.
interface byte_if import u8sd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface char_if import u8sd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CP_W-1:0]  code_point;
	logic             char_valid;
	logic             done_res;
	logic [CNT_W-1:0] char_count;
	logic [ST_W-1:0]  status;

	modport source (output valid, output code_point, output char_valid, output done_res,
		output char_count, output status, input ready);
	modport sink (input valid, input code_point, input char_valid, input done_res,
		input char_count, input status, output ready);
endinterface

// File: rtl/u8sd_front.sv
// Front end: accept bytes and classify them before queuing.
module u8sd_front import u8sd_pkg::*; (
	byte_if.sink      byte_in,
	input  logic      full,
	output logic      push,
	output q_entry_t  push_data
);

	byte_cls_t cls;

	always_comb begin
		if (!byte_in.data_byte[7]) begin
			cls = CLS_ASCII;
		end else if (byte_in.data_byte[6] == 1'b0) begin
			cls = CLS_CONT;
		end else if (byte_in.data_byte[5] == 1'b0) begin
			cls = CLS_LEAD2;
		end else if (byte_in.data_byte[4] == 1'b0) begin
			cls = CLS_LEAD3;
		end else if (byte_in.data_byte[3] == 1'b0) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_BAD;
		end
	end

	assign byte_in.ready  = !full;
	assign push           = byte_in.valid && !full;
	assign push_data.cls  = cls;
	assign push_data.data = byte_in.data_byte;
	assign push_data.last = byte_in.last_byte;

endmodule

// File: rtl/u8sd_fifo.sv
// Short queue of classified bytes between front and back end.
module u8sd_fifo import u8sd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/u8sd_back.sv
// Back end: decode state, character assembly and the output register.
module u8sd_back import u8sd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] max_chars,
	input  q_entry_t         head,
	input  logic             empty,
	output logic             pop,
	char_if.source           char_out
);

	logic [CP_W-1:0]  pv_q, pv_n;
	logic [1:0]       due_q, due_n;
	logic             bad_q, bad_n;
	logic             halted_q, halt_n;
	logic [CNT_W-1:0] count_q, cnt_n;
	logic             got;
	logic [CP_W-1:0]  cp;
	status_t          st;
	logic             emit;

	logic             out_valid_q;
	logic [CP_W-1:0]  cp_q;
	logic             char_valid_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_out_q;
	status_t          st_q;

	assign pop = !empty && (!out_valid_q || char_out.ready);

	always_comb begin
		pv_n   = pv_q;
		due_n  = due_q;
		bad_n  = bad_q;
		halt_n = halted_q;
		cnt_n  = count_q;
		got    = 1'b0;
		cp     = '0;
		st     = ST_OK;
		if (!halted_q && count_q < max_chars) begin
			if (due_q == 2'd0) begin
				case (head.cls)
					CLS_ASCII: begin
						cp  = CP_W'(head.data[6:0]);
						got = 1'b1;
					end
					CLS_CONT: begin
						// skip stray continuation
					end
					CLS_LEAD2: begin
						pv_n  = CP_W'(head.data[4:0]);
						due_n = 2'd1;
						bad_n = 1'b0;
					end
					CLS_LEAD3: begin
						pv_n  = CP_W'(head.data[3:0]);
						due_n = 2'd2;
						bad_n = 1'b0;
					end
					CLS_LEAD4: begin
						pv_n  = CP_W'(head.data[2:0]);
						due_n = 2'd3;
						bad_n = 1'b0;
					end
					default: begin
						halt_n = 1'b1;
						due_n  = 2'd0;
						bad_n  = 1'b0;
					end
				endcase
			end else begin
				bad_n = bad_q | (head.cls != CLS_CONT);
				pv_n  = {pv_q[CP_W-7:0], head.data[5:0]};
				due_n = due_q - 2'd1;
				if (due_n == 2'd0) begin
					if (bad_n) begin
						halt_n = 1'b1;
						bad_n  = 1'b0;
					end else begin
						cp  = pv_n;
						got = 1'b1;
					end
					pv_n = '0;
				end
			end
			if (got) begin
				cnt_n = count_q + 1'b1;
			end
		end
		if (head.last) begin
			if (halt_n) begin
				st = ST_MALFORMED;
			end else if (cnt_n >= max_chars) begin
				st = ST_OK;
			end else if (due_n != 2'd0) begin
				st = ST_INCOMPLETE;
			end else begin
				st = ST_OK;
			end
		end
		emit = got || head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q        <= '0;
			due_q       <= '0;
			bad_q       <= 1'b0;
			halted_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					pv_q     <= '0;
					due_q    <= '0;
					bad_q    <= 1'b0;
					halted_q <= 1'b0;
					count_q  <= '0;
				end else begin
					pv_q     <= pv_n;
					due_q    <= due_n;
					bad_q    <= bad_n;
					halted_q <= halt_n;
					count_q  <= cnt_n;
				end
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q         <= cp;
			char_valid_q <= got;
			done_q       <= head.last;
			cnt_out_q    <= cnt_n;
			st_q         <= st;
		end
	end

	assign char_out.valid      = out_valid_q;
	assign char_out.code_point = cp_q;
	assign char_out.char_valid = char_valid_q;
	assign char_out.done_res   = done_q;
	assign char_out.char_count = cnt_out_q;
	assign char_out.status     = st_q;

endmodule

// File: rtl/utf8_stream_decoder.sv
// Bytes are queued, decoded at the queue head, and each result is held in the output register.
// Throughput: one byte per cycle, sustained while the result side takes one item per cycle.
// The byte queue (QUEUE_DEPTH entries) lets the input keep flowing during short output stalls.
// Reset (arst_n low, asynchronous): queue empty, decode state cleared, no result pending,
// max_chars back to 65535.
module utf8_stream_decoder import u8sd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	byte_if.sink             byte_in,
	char_if.source           char_out,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

`include "utf8_stream_decoder_macros.svh"

	// Character limit per buffer; the user must write it only while the block is idle (not enforced).
	logic [CNT_W-1:0] max_chars_q;

	logic     push;
	q_entry_t push_data;
	logic     full;
	logic     pop;
	q_entry_t head;
	logic     empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= '1;
		end else if (cfg_we) begin
			max_chars_q <= cfg_wdata;
		end
	end

	// Classify each byte as it arrives: ASCII, continuation, lead of 2/3/4, or invalid lead.
	u8sd_front u_front (
		.byte_in   (byte_in),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple byte intake from decoding so each side can stall on its own.
	u8sd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Assemble code points, track limit and errors, and hold the result in a register.
	u8sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_chars (max_chars_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.char_out  (char_out)
	);

	// Every result carries a character, ends the buffer, or both.
	`U8SD_ASSERT(a_result_has_purpose,
		char_out.valid |-> (char_out.char_valid || char_out.done_res),
		"result with neither character nor end of buffer")
	// Status is reported only on the result that ends the buffer.
	`U8SD_ASSERT(a_status_on_done,
		(char_out.valid && !char_out.done_res) |-> (char_out.status == ST_OK),
		"status set on a result that does not end the buffer")
	// A result carrying a character has counted it.
	`U8SD_ASSERT(a_char_counted,
		(char_out.valid && char_out.char_valid) |-> (char_out.char_count != '0),
		"character emitted with zero count")
	// Nothing is shown right after reset.
	`U8SD_ASSERT_ALWAYS(a_reset_idle,
		!arst_n |=> !char_out.valid,
		"result pending after reset")

endmodule
